// ----- sv/lcdfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdfr_pkg
// Types, constants and power-up tables shared by the LCD frame refresher.
// ----------------------------------------------------------------------------
package lcdfr_pkg;

  localparam int FRAME_CHARS   = 32;
  localparam int ROW_CHARS     = 16;
  localparam int POWERUP_TICKS = 100;
  localparam int INIT_STEPS    = 9;
  localparam int IDX_W         = $clog2(FRAME_CHARS);

  localparam logic [1:0] CMD_TICK       = 2'd0;
  localparam logic [1:0] CMD_SET_POS    = 2'd1;
  localparam logic [1:0] CMD_WRITE_CHAR = 2'd2;

  localparam logic [7:0] LCD_ROW0_ADDR = 8'h80;
  localparam logic [7:0] LCD_ROW1_ADDR = 8'hC0;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] column;
    logic       row;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_ROW0_ADDR,
    PH_ROW0_CHARS,
    PH_ROW1_ADDR,
    PH_ROW1_CHARS
  } phase_t;

  // Load request from the controller to the nibble serialiser.
  typedef struct packed {
    logic       valid;
    logic       rs;
    logic [7:0] value;
    logic       two;
  } res_load_t;

  function automatic logic [6:0] init_wait(input logic [3:0] step);
    logic [6:0] w;
    unique case (step)
      4'd0:    w = 7'(POWERUP_TICKS);
      4'd1:    w = 7'd15;
      4'd2:    w = 7'd5;
      4'd3:    w = 7'd5;
      4'd4:    w = 7'd1;
      4'd5:    w = 7'd2;
      4'd6:    w = 7'd2;
      4'd7:    w = 7'd3;
      4'd8:    w = 7'd2;
      default: w = 7'd0;
    endcase
    return w;
  endfunction

  // Bit 8 set marks a lone nibble in the low four bits.
  function automatic logic [8:0] init_code(input logic [3:0] step);
    logic [8:0] c;
    unique case (step)
      4'd0:    c = 9'h103;
      4'd1:    c = 9'h103;
      4'd2:    c = 9'h103;
      4'd3:    c = 9'h102;
      4'd4:    c = 9'h028;
      4'd5:    c = 9'h008;
      4'd6:    c = 9'h001;
      4'd7:    c = 9'h006;
      4'd8:    c = 9'h00C;
      default: c = 9'h000;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/lcdfr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdfr_ctrl
// Frame store, cursor, power-up sequencer and refresh scan. Works out the
// byte or nibble that one registered command produces.
// ----------------------------------------------------------------------------
module lcdfr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  lcdfr_pkg::in_item_t  item,
  output lcdfr_pkg::res_load_t res_load
);

  logic [7:0]        frame_r [lcdfr_pkg::FRAME_CHARS];
  logic [5:0]        cursor_r;
  logic [5:0]        scan_r, scan_nxt;
  lcdfr_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]        init_step_r, init_step_nxt;
  logic [6:0]        delay_r, delay_nxt;
  logic              init_done_r, init_done_nxt;

  logic       tick_go;
  logic [5:0] scan_inc;
  logic [6:0] delay_inc;
  logic [6:0] wait_now;
  logic [8:0] code_now;
  logic       step_fires;
  logic [7:0] scan_char;

  assign tick_go    = go && (item.cmd == lcdfr_pkg::CMD_TICK);
  assign scan_inc   = scan_r + 6'd1;
  assign delay_inc  = delay_r + 7'd1;
  assign wait_now   = lcdfr_pkg::init_wait(init_step_r);
  assign code_now   = lcdfr_pkg::init_code(init_step_r);
  assign step_fires = (init_step_r < 4'(lcdfr_pkg::INIT_STEPS)) && !(delay_inc < wait_now);
  assign scan_char  = frame_r[scan_r[lcdfr_pkg::IDX_W-1:0]];

  // Refresh scan: next phase and character index.
  always_comb begin
    phase_nxt = phase_r;
    scan_nxt  = scan_r;
    if (tick_go && init_done_r) begin
      unique case (phase_r)
        lcdfr_pkg::PH_ROW0_ADDR: begin
          scan_nxt  = '0;
          phase_nxt = lcdfr_pkg::PH_ROW0_CHARS;
        end
        lcdfr_pkg::PH_ROW0_CHARS: begin
          scan_nxt = scan_inc;
          if (scan_inc == 6'(lcdfr_pkg::ROW_CHARS)) phase_nxt = lcdfr_pkg::PH_ROW1_ADDR;
        end
        lcdfr_pkg::PH_ROW1_ADDR: begin
          phase_nxt = lcdfr_pkg::PH_ROW1_CHARS;
        end
        lcdfr_pkg::PH_ROW1_CHARS: begin
          scan_nxt = scan_inc;
          if (scan_inc == 6'(lcdfr_pkg::FRAME_CHARS)) phase_nxt = lcdfr_pkg::PH_ROW0_ADDR;
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Power-up sequencer: wait counter and step index.
  always_comb begin
    init_step_nxt = init_step_r;
    delay_nxt     = delay_r;
    init_done_nxt = init_done_r;
    if (tick_go && !init_done_r) begin
      if (init_step_r >= 4'(lcdfr_pkg::INIT_STEPS)) begin
        init_done_nxt = 1'b1;
      end else if (step_fires) begin
        delay_nxt     = '0;
        init_step_nxt = init_step_r + 4'd1;
        if (init_step_nxt >= 4'(lcdfr_pkg::INIT_STEPS)) init_done_nxt = 1'b1;
      end else begin
        delay_nxt = delay_inc;
      end
    end
  end

  // Result of this tick, if any.
  always_comb begin
    res_load = '0;
    if (tick_go) begin
      if (init_done_r) begin
        res_load.valid = 1'b1;
        res_load.two   = 1'b1;
        unique case (phase_r)
          lcdfr_pkg::PH_ROW0_ADDR: begin
            res_load.rs    = 1'b0;
            res_load.value = lcdfr_pkg::LCD_ROW0_ADDR;
          end
          lcdfr_pkg::PH_ROW1_ADDR: begin
            res_load.rs    = 1'b0;
            res_load.value = lcdfr_pkg::LCD_ROW1_ADDR;
          end
          default: begin
            res_load.rs    = 1'b1;
            res_load.value = scan_char;
          end
        endcase
      end else if (step_fires) begin
        res_load.valid = 1'b1;
        res_load.rs    = 1'b0;
        res_load.two   = !code_now[8];
        res_load.value = code_now[8] ? {4'h0, code_now[3:0]} : code_now[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lcdfr_pkg::FRAME_CHARS; i++) frame_r[i] <= lcdfr_pkg::CHAR_SPACE;
      cursor_r    <= '0;
      scan_r      <= '0;
      phase_r     <= lcdfr_pkg::PH_ROW0_ADDR;
      init_step_r <= '0;
      delay_r     <= '0;
      init_done_r <= 1'b0;
    end else begin
      scan_r      <= scan_nxt;
      phase_r     <= phase_nxt;
      init_step_r <= init_step_nxt;
      delay_r     <= delay_nxt;
      init_done_r <= init_done_nxt;
      if (go && item.cmd == lcdfr_pkg::CMD_SET_POS) begin
        cursor_r <= {1'b0, item.row, item.column};
      end
      // Writes past the end of the frame are dropped and the cursor stays put.
      if (go && item.cmd == lcdfr_pkg::CMD_WRITE_CHAR && !cursor_r[5]) begin
        frame_r[cursor_r[lcdfr_pkg::IDX_W-1:0]] <= item.char_code;
        cursor_r <= cursor_r + 6'd1;
      end
    end
  end

endmodule

// ----- sv/lcdfr_outbuf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdfr_outbuf
// Result register: holds one byte or lone nibble and hands it out as nibble
// transactions, high nibble first.
// ----------------------------------------------------------------------------
module lcdfr_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcdfr_pkg::res_load_t res_load,
  output logic                 buf_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lcdfr_pkg::out_item_t out_data
);

  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] value_r;
  logic       rs_r;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign buf_free  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);

  assign out_data.reg_select = rs_r;
  assign out_data.nibble     = (cnt_r == 2'd2) ? value_r[7:4] : value_r[3:0];
  assign out_data.last       = (cnt_r != 2'd2);

  always_comb begin
    cnt_nxt = cnt_r;
    if (pop) cnt_nxt = cnt_r - 2'd1;
    if (res_load.valid) cnt_nxt = res_load.two ? 2'd2 : 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load.valid) begin
      value_r <= res_load.value;
      rs_r    <= res_load.rs;
    end
  end

endmodule

// ----- sv/char_lcd_frame_refresher_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_frame_refresher_core
// Character LCD refresher for a 2x16 display on a 4-bit bus, fed by a
// 32-character frame store and a millisecond tick.
// ----------------------------------------------------------------------------
// Path: a command is held in the input register; a tick that yields a result
// loads the result register, which hands out the high nibble, then the low one.
// Throughput: one position or character command per cycle unless a tick
// waits in the input register for the nibble serialiser to become free.
// Reset: synchronous; the frame store fills with spaces in the reset cycle.
module char_lcd_frame_refresher_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lcdfr_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lcdfr_pkg::out_item_t out_data
);

  logic                 in_valid_r;
  lcdfr_pkg::in_item_t  in_data_r;
  logic                 advance;
  logic                 buf_free;
  lcdfr_pkg::res_load_t res_load;

  // Only a tick needs room in the result register.
  assign advance  = in_valid_r && ((in_data_r.cmd != lcdfr_pkg::CMD_TICK) || buf_free);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_data_r <= in_data;
    end
  end

  lcdfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (advance),
    .item     (in_data_r),
    .res_load (res_load)
  );

  lcdfr_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .buf_free  (buf_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A new result must never overwrite one still being handed out.
  assert property (@(posedge clk) disable iff (!rst_n) res_load.valid |-> buf_free)
    else $error("result loaded while serialiser busy");

  // The low nibble follows the high nibble, with the same register select.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last) |=>
      (out_valid && out_data.reg_select == $past(out_data.reg_select)))
    else $error("low nibble missing after high nibble");

  // Only a tick can produce a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_load.valid |-> (advance && in_data_r.cmd == lcdfr_pkg::CMD_TICK))
    else $error("result produced by a non-tick command");

endmodule

// ----- verif/char_lcd_frame_refresher_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_frame_refresher_core_tb
// Self-checking bench for the 2x16 character LCD refresher. Position and
// character commands are mixed with bursts of millisecond ticks. A strobe
// predictor follows the power-up sequence and the refresh scan, and every
// nibble strobe is checked against it. Both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module char_lcd_frame_refresher_core_tb;

  localparam logic [1:0]  CMD_UNUSED       = 2'd3;
  localparam int          PWR_NIBBLE_STEPS = 4;
  localparam int          RANDOM_ITEMS     = 1700;
  localparam int          DRAIN_CYCLES     = 16;
  localparam int          STALL_LIMIT      = 2000;
  localparam int unsigned IDLE_PERCENT     = 22;

  // Predicts the nibble strobes caused by each accepted command.
  class lcd_strobe_predictor;
    logic [7:0]           frame [lcdfr_pkg::FRAME_CHARS];
    logic [6:0]           delay_tbl [lcdfr_pkg::INIT_STEPS];
    logic [7:0]           code_tbl [lcdfr_pkg::INIT_STEPS];
    logic [5:0]           cursor;
    logic [5:0]           scan_idx;
    lcdfr_pkg::phase_t    phase;
    logic [3:0]           init_step;
    logic [6:0]           tick_count;
    bit                   init_done;
    lcdfr_pkg::out_item_t pending_strobes[$];
    int unsigned          mismatches;
    int unsigned          strobes_checked;
    int unsigned          ticks_seen;
    int unsigned          refresh_ticks;
    int unsigned          writes_stored;

    function new();
      delay_tbl = '{7'(lcdfr_pkg::POWERUP_TICKS), 7'd15, 7'd5, 7'd5, 7'd1, 7'd2, 7'd2,
                    7'd3, 7'd2};
      code_tbl  = '{8'h03, 8'h03, 8'h03, 8'h02, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};
      foreach (frame[i]) frame[i] = lcdfr_pkg::CHAR_SPACE;
      cursor          = '0;
      scan_idx        = '0;
      phase           = lcdfr_pkg::PH_ROW0_ADDR;
      init_step       = '0;
      tick_count      = '0;
      init_done       = 1'b0;
      mismatches      = 0;
      strobes_checked = 0;
      ticks_seen      = 0;
      refresh_ticks   = 0;
      writes_stored   = 0;
    endfunction

    function void push_strobe(logic rs, logic [3:0] nib, logic fin);
      lcdfr_pkg::out_item_t s;
      s.reg_select = rs;
      s.nibble     = nib;
      s.last       = fin;
      pending_strobes.push_back(s);
    endfunction

    // A byte leaves as two strobes, high nibble first.
    function void push_byte(logic rs, logic [7:0] value);
      push_strobe(rs, value[7:4], 1'b0);
      push_strobe(rs, value[3:0], 1'b1);
    endfunction

    function void tick_step();
      logic [7:0] ch;
      ticks_seen++;
      if (!init_done) begin
        if (init_step >= lcdfr_pkg::INIT_STEPS) begin
          init_done = 1'b1;
          return;
        end
        tick_count = tick_count + 7'd1;
        if (tick_count < delay_tbl[init_step]) return;
        tick_count = '0;
        if (init_step < PWR_NIBBLE_STEPS) push_strobe(1'b0, code_tbl[init_step][3:0], 1'b1);
        else push_byte(1'b0, code_tbl[init_step]);
        init_step = init_step + 4'd1;
        if (init_step >= lcdfr_pkg::INIT_STEPS) init_done = 1'b1;
        return;
      end
      refresh_ticks++;
      case (phase)
        lcdfr_pkg::PH_ROW0_ADDR: begin
          scan_idx = '0;
          phase    = lcdfr_pkg::PH_ROW0_CHARS;
          push_byte(1'b0, lcdfr_pkg::LCD_ROW0_ADDR);
        end
        lcdfr_pkg::PH_ROW0_CHARS: begin
          ch       = frame[scan_idx[4:0]];
          scan_idx = scan_idx + 6'd1;
          if (scan_idx == lcdfr_pkg::ROW_CHARS) phase = lcdfr_pkg::PH_ROW1_ADDR;
          push_byte(1'b1, ch);
        end
        lcdfr_pkg::PH_ROW1_ADDR: begin
          phase = lcdfr_pkg::PH_ROW1_CHARS;
          push_byte(1'b0, lcdfr_pkg::LCD_ROW1_ADDR);
        end
        default: begin
          ch       = frame[scan_idx[4:0]];
          scan_idx = scan_idx + 6'd1;
          if (scan_idx == lcdfr_pkg::FRAME_CHARS) phase = lcdfr_pkg::PH_ROW0_ADDR;
          push_byte(1'b1, ch);
        end
      endcase
    endfunction

    function void note_input(lcdfr_pkg::in_item_t item);
      case (item.cmd)
        lcdfr_pkg::CMD_TICK: tick_step();
        lcdfr_pkg::CMD_SET_POS:
          cursor = 6'(item.column) + (item.row ? 6'(lcdfr_pkg::ROW_CHARS) : 6'd0);
        lcdfr_pkg::CMD_WRITE_CHAR: begin
          // Writes past the end of the frame are dropped and the cursor stays.
          if (cursor < lcdfr_pkg::FRAME_CHARS) begin
            frame[cursor[4:0]] = item.char_code;
            cursor = cursor + 6'd1;
            writes_stored++;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(lcdfr_pkg::out_item_t got);
      lcdfr_pkg::out_item_t want;
      if (pending_strobes.size() == 0) begin
        $error("unexpected strobe: reg_select %0d nibble %h last %0d",
               got.reg_select, got.nibble, got.last);
        mismatches++;
        return;
      end
      want = pending_strobes.pop_front();
      strobes_checked++;
      if (got.reg_select !== want.reg_select) begin
        $error("reg_select: expected %0d, actual %0d", want.reg_select, got.reg_select);
        mismatches++;
      end
      if (got.nibble !== want.nibble) begin
        $error("nibble: expected %h, actual %h", want.nibble, got.nibble);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        mismatches++;
      end
    endfunction

    function int pending_count();
      return pending_strobes.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  lcdfr_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_ready;
  lcdfr_pkg::out_item_t out_data;

  bit          calm;
  int unsigned stall_cycles;
  lcd_strobe_predictor strobe_model;

  char_lcd_frame_refresher_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial out_ready = 1'b0;

  always @(negedge clk) begin
    out_ready = calm || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Results are checked before the input of the same edge is noted, since a
  // strobe always belongs to an earlier transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if (out_valid && out_ready) strobe_model.check_result(out_data);
      if (in_valid && in_ready) strobe_model.note_input(in_data);
      if ((out_valid && out_ready) || (in_valid && in_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $error("no transaction for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_item(input logic [1:0] cmd, input logic [3:0] column,
                           input logic row, input logic [7:0] char_code);
    lcdfr_pkg::in_item_t item;
    item.cmd       = cmd;
    item.column    = column;
    item.row       = row;
    item.char_code = char_code;
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(input logic [1:0] cmd);
    send_item(cmd, 4'($urandom_range(15)), 1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  task automatic drain_strobes();
    @(negedge clk);
    in_valid = 1'b0;
    while (strobe_model.pending_count() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned pick;
    int unsigned burst;
    bit          paused;
    strobe_model = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    calm     = 1'b0;
    sent     = 0;
    paused   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed edits: both ends of each row, an overrun past the last
    // character, the unused command code and ticks with extreme fields.
    send_item(lcdfr_pkg::CMD_SET_POS,    4'd0,  1'b0, 8'h00);
    send_item(lcdfr_pkg::CMD_WRITE_CHAR, 4'd0,  1'b0, 8'h00);
    send_item(lcdfr_pkg::CMD_WRITE_CHAR, 4'hF,  1'b1, 8'hFF);
    send_item(lcdfr_pkg::CMD_SET_POS,    4'd15, 1'b0, 8'hFF);
    send_item(lcdfr_pkg::CMD_WRITE_CHAR, 4'd0,  1'b0, 8'hA5);
    send_item(lcdfr_pkg::CMD_WRITE_CHAR, 4'd0,  1'b0, 8'h5A);
    send_item(lcdfr_pkg::CMD_SET_POS,    4'd15, 1'b1, 8'h00);
    send_item(lcdfr_pkg::CMD_WRITE_CHAR, 4'd0,  1'b0, 8'h7E);
    send_item(lcdfr_pkg::CMD_WRITE_CHAR, 4'd0,  1'b0, 8'h81);
    send_item(lcdfr_pkg::CMD_WRITE_CHAR, 4'd0,  1'b0, 8'h33);
    send_item(CMD_UNUSED,                4'hF,  1'b1, 8'hFF);
    send_item(lcdfr_pkg::CMD_SET_POS,    4'd0,  1'b1, 8'h00);
    send_item(lcdfr_pkg::CMD_WRITE_CHAR, 4'd0,  1'b0, 8'h41);
    send_item(lcdfr_pkg::CMD_TICK,       4'hF,  1'b1, 8'hFF);
    send_item(lcdfr_pkg::CMD_TICK,       4'd0,  1'b0, 8'h00);

    // Random part: tick bursts and lines of text, with some stray commands.
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= 600 && sent < 900);
      if (!paused && sent >= 1100) begin
        drain_strobes();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        burst = $urandom_range(30, 1);
        repeat (burst) send_random(lcdfr_pkg::CMD_TICK);
        sent += burst;
      end else if (pick < 85) begin
        burst = $urandom_range(18, 1);
        send_random(lcdfr_pkg::CMD_SET_POS);
        repeat (burst) send_random(lcdfr_pkg::CMD_WRITE_CHAR);
        sent += burst + 1;
      end else if (pick < 93) begin
        send_random(lcdfr_pkg::CMD_WRITE_CHAR);
        sent++;
      end else if (pick < 97) begin
        send_random(lcdfr_pkg::CMD_SET_POS);
        sent++;
      end else begin
        send_random(CMD_UNUSED);
      end
    end
    calm = 1'b0;

    drain_strobes();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d ticks (%0d refresh steps) and %0d stored characters.",
             strobe_model.ticks_seen, strobe_model.refresh_ticks,
             strobe_model.writes_stored);
    $display("Checked %0d nibble strobes, power-up sequence %s.",
             strobe_model.strobes_checked,
             strobe_model.init_done ? "completed" : "not completed");
    if (strobe_model.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
